FILE: design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, codes and byte classifiers for the MIME type sniffer.
// ----------------------------------------------------------------------------
package mts_pkg;

	typedef enum logic [1:0] {
		REQ_PAT_BYTE = 2'd0,
		REQ_PAT_ATTR = 2'd1,
		REQ_DATA     = 2'd2,
		REQ_END      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		VERDICT_MATCH = 2'd0,
		VERDICT_OCTET = 2'd1,
		VERDICT_TEXT  = 2'd2,
		VERDICT_KEEP  = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		CLASS_UNKNOWN = 2'd0,
		CLASS_PLAIN   = 2'd1,
		CLASS_OTHER   = 2'd2
	} class_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef enum logic {
		ACT_CMP,
		ACT_TERM
	} act_t;

	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_GT    = 8'h3E;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0C) || (b == 8'h0D) ||
			(b == 8'h20);
	endfunction

	function automatic logic is_binary(input logic [7:0] b);
		return (b <= 8'h08) || (b == 8'h0B) || ((b >= 8'h0E) && (b <= 8'h1A)) ||
			((b >= 8'h1C) && (b <= 8'h1F));
	endfunction

endpackage

FILE: design/mts_pattern_ram.sv
// ----------------------------------------------------------------------------
// mts_pattern_ram
// Pattern value and mask store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mts_pattern_ram import mts_pkg::*; #(
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [15:0]       wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [15:0]       rd_data
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: design/mime_type_sniffer_core.sv
// ----------------------------------------------------------------------------
// mime_type_sniffer_core
// Masked pattern sniffer with binary byte and byte order mark tracking.
// ----------------------------------------------------------------------------
// A resource byte walks the table, one pattern memory read per entry. A final
// byte or end item adds a scan of the table and an output state.
// Reset clears the attribute table (empty table) and all per-resource state;
// the value and mask memory is undefined until written.
// ----------------------------------------------------------------------------
module mime_type_sniffer_core import mts_pkg::*; #(
	parameter int NUM_PATTERNS    = 32,
	parameter int MAX_PATTERN_LEN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// pattern_index[4:0] byte_index[8:5] pattern_byte[16:9] mask_byte[24:17]
	// pattern_length[29:25] lead_skip[30] want_terminator[31]
	// data_byte[39:32] declared_class[41:40] zero[47:42]
	input  logic [47:0] s_axis_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// verdict[1:0] matched_pattern[6:2] zero[7]
	output logic [7:0]  m_axis_tdata
);

	localparam int IW     = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
	localparam int LW     = $clog2(MAX_PATTERN_LEN + 1);
	localparam int PW     = $clog2(MAX_PATTERN_LEN + 2);
	localparam int DEPTH  = NUM_PATTERNS * MAX_PATTERN_LEN;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [4:0] in_pidx;
	logic [3:0] in_bidx;
	logic [7:0] in_pbyte, in_mask, in_data;
	logic [4:0] in_plen;
	logic       in_skip, in_term;
	logic [1:0] in_cls_raw;
	class_t     in_cls;
	req_t       in_req;

	assign in_pidx    = s_axis_tdata[4:0];
	assign in_bidx    = s_axis_tdata[8:5];
	assign in_pbyte   = s_axis_tdata[16:9];
	assign in_mask    = s_axis_tdata[24:17];
	assign in_plen    = s_axis_tdata[29:25];
	assign in_skip    = s_axis_tdata[30];
	assign in_term    = s_axis_tdata[31];
	assign in_data    = s_axis_tdata[39:32];
	assign in_cls_raw = s_axis_tdata[41:40];
	assign in_cls     = (in_cls_raw == 2'd3) ? CLASS_OTHER : class_t'(in_cls_raw);
	assign in_req     = req_t'(s_axis_tuser);

	state_t state_q, state_d;
	logic   accept;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	logic [LW-1:0] attr_len_q  [NUM_PATTERNS];
	logic          attr_skip_q [NUM_PATTERNS];
	logic          attr_term_q [NUM_PATTERNS];

	logic [NUM_PATTERNS-1:0] alive_q, complete_q;
	logic [PW-1:0] pos_q, skp_q, cur_pos_q, cur_skp_q;
	logic          lead_done_q, ws_lead_q, binary_q, in_res_q, last_q;
	logic [7:0]    b0_q, b1_q, b2_q, byte_q;
	class_t        class_q;
	logic [IW-1:0] idx_q;
	logic          found_q;
	logic [IW-1:0] found_idx_q;

	logic          s1_valid, s1_final;
	act_t          s1_act;
	logic [IW-1:0] s1_idx;

	// pattern memory
	logic              ram_wr;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [15:0]       ram_rdata;

	assign ram_wr    = accept && (in_req == REQ_PAT_BYTE) &&
		(32'(in_pidx) < NUM_PATTERNS) && (32'(in_bidx) < MAX_PATTERN_LEN);
	assign ram_waddr = ADDR_W'(ADDR_W'(in_pidx) * ADDR_W'(MAX_PATTERN_LEN) +
		ADDR_W'(in_bidx));

	mts_pattern_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (ram_waddr),
		.wr_data ({in_mask, in_pbyte}),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// walk decode for the current entry
	logic [LW-1:0] cur_len;
	logic          cur_skip, cur_term, cur_live, tbl_end, idx_last;
	logic [PW-1:0] cur_off;
	logic          issue, issue_cmp, issue_term;

	assign cur_len  = attr_len_q[idx_q];
	assign cur_skip = attr_skip_q[idx_q];
	assign cur_term = attr_term_q[idx_q];
	assign tbl_end  = (cur_len == '0);
	assign idx_last = (32'(idx_q) == NUM_PATTERNS - 1);
	assign cur_live = alive_q[idx_q] && !complete_q[idx_q] && !(cur_skip && ws_lead_q);
	assign cur_off  = cur_skip ? cur_skp_q : cur_pos_q;
	assign issue_cmp  = cur_live && (cur_off < PW'(cur_len));
	assign issue_term = cur_live && (cur_off == PW'(cur_len));
	assign issue      = (state_q == ST_WALK) && !tbl_end && (issue_cmp || issue_term);
	assign ram_raddr  = ADDR_W'(ADDR_W'(idx_q) * ADDR_W'(MAX_PATTERN_LEN) +
		ADDR_W'(cur_off));

	// verdict
	logic     bom, out_fire;
	verdict_t verdict;

	always_comb begin
		bom = ((pos_q >= PW'(2)) && (((b0_q == 8'hFF) && (b1_q == 8'hFE)) ||
			((b0_q == 8'hFE) && (b1_q == 8'hFF)))) ||
			((pos_q >= PW'(3)) && (b0_q == 8'hEF) && (b1_q == 8'hBB) &&
			(b2_q == 8'hBF));
		case (class_q)
			CLASS_UNKNOWN: verdict = found_q ? VERDICT_MATCH :
				(binary_q ? VERDICT_OCTET : VERDICT_TEXT);
			CLASS_PLAIN:   verdict = bom ? VERDICT_TEXT :
				(binary_q ? VERDICT_OCTET : VERDICT_TEXT);
			default:       verdict = VERDICT_KEEP;
		endcase
	end

	assign out_fire = (state_q == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_req == REQ_DATA)) state_d = ST_WALK;
				else if (accept && (in_req == REQ_END)) state_d = ST_SCAN;
			end
			ST_WALK: begin
				if (tbl_end || idx_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = last_q ? ST_SCAN : ST_IDLE;
			ST_SCAN: begin
				if (tbl_end || (alive_q[idx_q] && complete_q[idx_q]) || idx_last)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// attribute table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PATTERNS; i++) begin
				attr_len_q[i]  <= '0;
				attr_skip_q[i] <= 1'b0;
				attr_term_q[i] <= 1'b0;
			end
		end else if (accept && (in_req == REQ_PAT_ATTR) &&
			(32'(in_pidx) < NUM_PATTERNS)) begin
			attr_len_q[IW'(in_pidx)]  <= (32'(in_plen) > MAX_PATTERN_LEN) ?
				LW'(MAX_PATTERN_LEN) : LW'(in_plen);
			attr_skip_q[IW'(in_pidx)] <= in_skip;
			attr_term_q[IW'(in_pidx)] <= in_term;
		end
	end

	// compare stage
	logic [7:0] s1_val, s1_msk;
	assign s1_val = ram_rdata[7:0];
	assign s1_msk = ram_rdata[15:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_act   <= ACT_CMP;
			s1_idx   <= '0;
			s1_final <= 1'b0;
		end else begin
			s1_valid <= issue;
			s1_act   <= issue_cmp ? ACT_CMP : ACT_TERM;
			s1_idx   <= idx_q;
			s1_final <= (cur_off + PW'(1) == PW'(cur_len)) && !cur_term;
		end
	end

	// per-resource state
	logic ws_now;
	assign ws_now = !lead_done_q && is_space(in_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q     <= '1;
			complete_q  <= '0;
			pos_q       <= '0;
			skp_q       <= '0;
			cur_pos_q   <= '0;
			cur_skp_q   <= '0;
			lead_done_q <= 1'b0;
			ws_lead_q   <= 1'b0;
			binary_q    <= 1'b0;
			in_res_q    <= 1'b0;
			last_q      <= 1'b0;
			b0_q        <= '0;
			b1_q        <= '0;
			b2_q        <= '0;
			byte_q      <= '0;
			class_q     <= CLASS_UNKNOWN;
			idx_q       <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
		end else begin
			if (accept && (in_req == REQ_DATA)) begin
				if (!in_res_q) class_q <= in_cls;
				in_res_q    <= 1'b1;
				byte_q      <= in_data;
				last_q      <= s_axis_tlast;
				ws_lead_q   <= ws_now;
				cur_pos_q   <= pos_q;
				cur_skp_q   <= skp_q;
				idx_q       <= '0;
				if (!ws_now) lead_done_q <= 1'b1;
				if (is_binary(in_data)) binary_q <= 1'b1;
				if (pos_q == PW'(0)) b0_q <= in_data;
				if (pos_q == PW'(1)) b1_q <= in_data;
				if (pos_q == PW'(2)) b2_q <= in_data;
				if (32'(pos_q) < MAX_PATTERN_LEN + 1) pos_q <= pos_q + PW'(1);
				if (!ws_now && (32'(skp_q) < MAX_PATTERN_LEN + 1))
					skp_q <= skp_q + PW'(1);
			end
			if (accept && (in_req == REQ_END)) begin
				if (!in_res_q) class_q <= in_cls;
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if ((state_q == ST_WALK) && !idx_last) idx_q <= idx_q + IW'(1);
			if (state_q == ST_DRAIN) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (!tbl_end && alive_q[idx_q] && complete_q[idx_q]) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_q;
				end else if (!idx_last) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (s1_valid) begin
				case (s1_act)
					ACT_CMP: begin
						if ((byte_q & s1_msk) != s1_val) alive_q[s1_idx] <= 1'b0;
						else if (s1_final) complete_q[s1_idx] <= 1'b1;
					end
					ACT_TERM: begin
						if ((byte_q == BYTE_SPACE) || (byte_q == BYTE_GT))
							complete_q[s1_idx] <= 1'b1;
						else
							alive_q[s1_idx] <= 1'b0;
					end
					default: ;
				endcase
			end
			if (out_fire) begin
				alive_q     <= '1;
				complete_q  <= '0;
				pos_q       <= '0;
				skp_q       <= '0;
				lead_done_q <= 1'b0;
				binary_q    <= 1'b0;
				in_res_q    <= 1'b0;
				b0_q        <= '0;
				b1_q        <= '0;
				b2_q        <= '0;
				class_q     <= CLASS_UNKNOWN;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			if (out_fire) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tdata  <= {1'b0,
					(verdict == VERDICT_MATCH) ? 5'(found_idx_q) : 5'd0,
					verdict};
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

endmodule

FILE: test/mime_type_sniffer_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mime_type_sniffer_core_checker
// Watches both stream channels, keeps its own copy of the pattern table and
// per-resource sniffing state, predicts each verdict and compares it with the
// block's output in order.
// ----------------------------------------------------------------------------
module mime_type_sniffer_core_checker import mts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	output int          fail_count,
	output int          pending_verdicts
);

	localparam int NPAT = 32;
	localparam int PLEN = 16;
	localparam int POS_CAP = PLEN + 1;

	typedef struct packed {
		verdict_t   verdict;
		logic [4:0] index;
	} sniff_result_t;

	logic [7:0]    pat_value [NPAT*PLEN];
	logic [7:0]    pat_mask  [NPAT*PLEN];
	logic [4:0]    pat_len   [NPAT];
	logic          pat_skip  [NPAT];
	logic          pat_term  [NPAT];
	logic [31:0]   alive;
	logic [31:0]   complete;
	int            pos;
	int            skip_pos;
	logic          lead_done;
	logic [7:0]    head [3];
	logic          saw_binary;
	class_t        res_class;
	logic          open_res;
	sniff_result_t verdict_queue [$];

	function automatic logic ws_byte(input logic [7:0] b);
		return b == 8'h09 || b == 8'h0A || b == 8'h0C || b == 8'h0D || b == 8'h20;
	endfunction

	function automatic logic bin_byte(input logic [7:0] b);
		return b <= 8'h08 || b == 8'h0B || (b >= 8'h0E && b <= 8'h1A) ||
			(b >= 8'h1C && b <= 8'h1F);
	endfunction

	task automatic clear_sniff();
		alive = '1;
		complete = '0;
		pos = 0;
		skip_pos = 0;
		lead_done = 1'b0;
		head[0] = 8'h00;
		head[1] = 8'h00;
		head[2] = 8'h00;
		saw_binary = 1'b0;
		res_class = CLASS_UNKNOWN;
		open_res = 1'b0;
	endtask

	task automatic absorb(input logic [7:0] b);
		logic lead_ws;
		int   off;
		int   a;
		lead_ws = !lead_done && ws_byte(b);
		if (!lead_ws)
			lead_done = 1'b1;
		if (bin_byte(b))
			saw_binary = 1'b1;
		if (pos < 3)
			head[pos] = b;
		for (int i = 0; i < NPAT; i++) begin
			if (pat_len[i] == 0)
				break;
			if (!alive[i] || complete[i])
				continue;
			if (pat_skip[i] && lead_ws)
				continue;
			off = pat_skip[i] ? skip_pos : pos;
			if (off < pat_len[i]) begin
				a = i * PLEN + off;
				if ((b & pat_mask[a]) != pat_value[a])
					alive[i] = 1'b0;
				else if (off + 1 == pat_len[i] && !pat_term[i])
					complete[i] = 1'b1;
			end else if (off == pat_len[i]) begin
				if (b == BYTE_SPACE || b == BYTE_GT)
					complete[i] = 1'b1;
				else
					alive[i] = 1'b0;
			end
		end
		if (pos < POS_CAP)
			pos++;
		if (!lead_ws && skip_pos < POS_CAP)
			skip_pos++;
	endtask

	task automatic close_resource();
		sniff_result_t r;
		logic          bom;
		bom = (pos >= 2 && ((head[0] == 8'hFF && head[1] == 8'hFE) ||
			(head[0] == 8'hFE && head[1] == 8'hFF))) ||
			(pos >= 3 && head[0] == 8'hEF && head[1] == 8'hBB && head[2] == 8'hBF);
		r.index = '0;
		r.verdict = saw_binary ? VERDICT_OCTET : VERDICT_TEXT;
		if (res_class == CLASS_UNKNOWN) begin
			for (int i = 0; i < NPAT; i++) begin
				if (pat_len[i] == 0)
					break;
				if (alive[i] && complete[i]) begin
					r.verdict = VERDICT_MATCH;
					r.index = i[4:0];
					break;
				end
			end
		end else if (res_class == CLASS_PLAIN) begin
			if (bom)
				r.verdict = VERDICT_TEXT;
		end else begin
			r.verdict = VERDICT_KEEP;
		end
		verdict_queue.push_back(r);
		clear_sniff();
	endtask

	task automatic take_request(input logic [47:0] d, input logic [1:0] kind,
			input logic fin);
		class_t     cls;
		logic [4:0] len;
		int         a;
		cls = (d[41:40] == 2'd3) ? CLASS_OTHER : class_t'(d[41:40]);
		case (req_t'(kind))
			REQ_PAT_BYTE: begin
				a = d[4:0] * PLEN + d[8:5];
				pat_value[a] = d[16:9];
				pat_mask[a] = d[24:17];
			end
			REQ_PAT_ATTR: begin
				len = (d[29:25] > PLEN) ? 5'(PLEN) : d[29:25];
				pat_len[d[4:0]] = len;
				pat_skip[d[4:0]] = d[30];
				pat_term[d[4:0]] = d[31];
			end
			REQ_END: begin
				if (!open_res) begin
					clear_sniff();
					res_class = cls;
				end
				close_resource();
			end
			default: begin
				if (!open_res) begin
					res_class = cls;
					open_res = 1'b1;
				end
				absorb(d[39:32]);
				if (fin)
					close_resource();
			end
		endcase
	endtask

	initial begin
		for (int i = 0; i < NPAT*PLEN; i++) begin
			pat_value[i] = 8'h00;
			pat_mask[i] = 8'h00;
		end
		for (int i = 0; i < NPAT; i++) begin
			pat_len[i] = '0;
			pat_skip[i] = 1'b0;
			pat_term[i] = 1'b0;
		end
		clear_sniff();
		fail_count = 0;
	end

	assign pending_verdicts = verdict_queue.size();

	always @(posedge clk) begin
		sniff_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (verdict_queue.size() == 0) begin
				$display("%0t: unexpected verdict, expected none, actual %h",
					$time, m_axis_tdata);
				fail_count++;
			end else begin
				want = verdict_queue.pop_front();
				if (m_axis_tdata[1:0] != want.verdict) begin
					$display("%0t: verdict mismatch, expected %0d, actual %0d",
						$time, want.verdict, m_axis_tdata[1:0]);
					fail_count++;
				end
				if (m_axis_tdata[6:2] != want.index) begin
					$display("%0t: matched_pattern mismatch, expected %0d, actual %0d",
						$time, want.index, m_axis_tdata[6:2]);
					fail_count++;
				end
				if (m_axis_tdata[7] != 1'b0) begin
					$display("%0t: pad bit mismatch, expected 0, actual %b",
						$time, m_axis_tdata[7]);
					fail_count++;
				end
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			take_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
	end

endmodule

FILE: test/mime_type_sniffer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mime_type_sniffer_core_tb
// Loads pattern tables, streams directed and random resources through the
// sniffer with random gaps and backpressure; the checker predicts verdicts.
// ----------------------------------------------------------------------------
module mime_type_sniffer_core_tb;
	import mts_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	int          fail_count;
	int          pending_verdicts;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          quiet_cycles;
	logic [7:0]  pat_bytes [32][16];
	logic [7:0]  pat_masks [32][16];
	logic [4:0]  pat_lens  [32];
	logic        pat_skips [32];
	logic        pat_terms [32];
	int          table_size;

	mime_type_sniffer_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	mime_type_sniffer_core_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.fail_count(fail_count), .pending_verdicts(pending_verdicts)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// hold tvalid after the transaction; the next gap or drain drops it
	task automatic send(input req_t kind, input logic [47:0] d, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= d;
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic write_pat_byte(input int p, input int b, input logic [7:0] v,
			input logic [7:0] m);
		logic [47:0] d;
		d = '0;
		d[4:0] = p[4:0];
		d[8:5] = b[3:0];
		d[16:9] = v;
		d[24:17] = m;
		send(REQ_PAT_BYTE, d, 1'b0);
	endtask

	task automatic write_pat_attr(input int p, input logic [4:0] len,
			input logic skp, input logic trm);
		logic [47:0] d;
		d = '0;
		d[4:0] = p[4:0];
		d[29:25] = len;
		d[30] = skp;
		d[31] = trm;
		d[39:32] = $urandom;
		d[41:40] = $urandom;
		send(REQ_PAT_ATTR, d, $urandom_range(1));
	endtask

	task automatic send_byte(input logic [7:0] b, input logic [1:0] cls, input logic fin);
		logic [47:0] d;
		d = {6'd0, cls, b, 32'd0};
		d[31:0] = $urandom;
		send(REQ_DATA, d, fin);
	endtask

	task automatic send_end(input logic [1:0] cls);
		logic [47:0] d;
		d = {6'd0, cls, 8'($urandom), 32'($urandom)};
		send(REQ_END, d, $urandom_range(1));
	endtask

	// build and load a table; every written entry gets all its bytes first
	task automatic load_table(input int count);
		for (int p = 0; p < count; p++) begin
			pat_lens[p] = (p == 0 && count == 32) ? 5'd16 : 5'($urandom_range(1, 6));
			if ($urandom_range(9) == 0)
				pat_lens[p] = 5'($urandom_range(17, 31));
			pat_skips[p] = $urandom_range(1);
			pat_terms[p] = $urandom_range(3) == 0;
			for (int b = 0; b < 16; b++) begin
				pat_masks[p][b] = $urandom_range(1) ? 8'hFF : 8'($urandom);
				pat_bytes[p][b] = 8'($urandom) & pat_masks[p][b];
				if ($urandom_range(7) == 0)
					pat_bytes[p][b] = 8'($urandom);
				write_pat_byte(p, b, pat_bytes[p][b], pat_masks[p][b]);
			end
			write_pat_attr(p, pat_lens[p], pat_skips[p], pat_terms[p]);
		end
		table_size = count;
		if (count < 32)
			write_pat_attr(count, 5'd0, 1'b0, 1'b0);
	endtask

	task automatic random_resource(output int sent);
		logic [1:0] cls;
		logic [7:0] buf_bytes [$];
		int         p;
		int         n;
		cls = $urandom_range(3);
		if ($urandom_range(1))
			cls = 2'd0;
		buf_bytes = {};
		case ($urandom_range(5))
			0, 1, 2: begin
				if (table_size > 0) begin
					p = $urandom_range(table_size - 1);
					if (pat_skips[p])
						repeat ($urandom_range(2))
							buf_bytes.push_back($urandom_range(1) ? 8'h20 : 8'h09);
					n = (pat_lens[p] > 16) ? 16 : pat_lens[p];
					for (int b = 0; b < n; b++)
						buf_bytes.push_back((8'($urandom) & ~pat_masks[p][b]) |
							pat_bytes[p][b]);
					if (pat_terms[p] || $urandom_range(1))
						buf_bytes.push_back($urandom_range(3) == 0 ? 8'($urandom) :
							($urandom_range(1) ? BYTE_SPACE : BYTE_GT));
					if ($urandom_range(3) == 0 && buf_bytes.size() > 1)
						void'(buf_bytes.pop_back());
				end
			end
			3: begin
				case ($urandom_range(2))
					0: buf_bytes = {8'hFF, 8'hFE};
					1: buf_bytes = {8'hFE, 8'hFF};
					default: buf_bytes = {8'hEF, 8'hBB, 8'hBF};
				endcase
			end
			default: ;
		endcase
		repeat ($urandom_range(4))
			buf_bytes.push_back($urandom_range(2) == 0 ? 8'($urandom_range(31)) :
				8'($urandom));
		sent = buf_bytes.size() + 1;
		if (buf_bytes.size() == 0) begin
			send_end(cls);
		end else if ($urandom_range(9) == 0) begin
			foreach (buf_bytes[i])
				send_byte(buf_bytes[i], 2'($urandom), 1'b0);
			send_end(2'($urandom));
		end else begin
			foreach (buf_bytes[i])
				send_byte(buf_bytes[i], i == 0 ? cls : 2'($urandom),
					i == buf_bytes.size() - 1);
			sent--;
		end
	endtask

	task automatic drain_verdicts();
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
	endtask

	initial begin
		int items;
		int sent;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_PAT_BYTE;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		quiet_cycles = 0;
		table_size = 0;
		send_idle_pct = 16;
		recv_idle_pct = 65;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: empty resources of every class, then two one-byte resources
		for (int c = 0; c < 4; c++)
			send_end(c[1:0]);
		send_byte(8'h00, 2'd0, 1'b1);
		send_byte(8'h20, 2'd0, 1'b1);
		// directed table: "<h" (either case) with terminator, skipping; 0xFF; end entry; last byte slot
		write_pat_byte(0, 0, 8'h3C, 8'hFF);
		write_pat_byte(0, 1, 8'h48, 8'hDF);
		write_pat_attr(0, 5'd2, 1'b1, 1'b1);
		write_pat_byte(1, 0, 8'hFF, 8'hFF);
		write_pat_attr(1, 5'd1, 1'b0, 1'b0);
		write_pat_attr(2, 5'd0, 1'b0, 1'b0);
		write_pat_byte(31, 15, 8'hAA, 8'h55);
		send_byte(8'h0A, 2'd0, 1'b0);
		send_byte(8'h3C, 2'd3, 1'b0);
		send_byte(8'h68, 2'd1, 1'b0);
		send_byte(8'h3E, 2'd2, 1'b1);
		send_byte(8'h3C, 2'd0, 1'b0);
		send_byte(8'h48, 2'd0, 1'b1);
		send_byte(8'hFF, 2'd1, 1'b0);
		send_byte(8'hFE, 2'd1, 1'b0);
		send_byte(8'h01, 2'd1, 1'b1);
		send_byte(8'h09, 2'd0, 1'b0);
		send_end(2'd2);
		send_byte(8'h0C, 2'd0, 1'b0);
		send_byte(8'h0D, 2'd0, 1'b1);
		drain_verdicts();

		items = 0;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 65 : 0;
			recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 16 : 0;
			load_table(phase == 2 ? 32 : $urandom_range(1, 8));
			for (int k = 0; k < 150; k += sent) begin
				if ($urandom_range(19) == 0) begin
					write_pat_attr(table_size, 5'($urandom), $urandom_range(1),
						$urandom_range(1));
					drain_verdicts();
					if (table_size < 32)
						write_pat_attr(table_size, 5'd0, 1'b0, 1'b0);
					sent = 1;
				end else begin
					random_resource(sent);
				end
				items += sent;
			end
			drain_verdicts();
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
